// ===== src/sact_pkg.sv =====
// Package for the set-associative cache tag controller.
// Holds the word types, configuration register codes, reset constants and helpers.
// No dependencies.
`timescale 1ns / 1ps

package sact_pkg;

    localparam int SETS_DEF   = 8;
    localparam int WAYS_DEF   = 4;
    localparam int ADDR_W     = 32;
    localparam int CNT_W      = 32;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [15:0] LFSR_MASK    = 16'hB400;
    localparam logic [15:0] SEED_RESET   = 16'd44257;
    localparam logic [3:0]  OFFSET_RESET = 4'd4;
    localparam logic        MODE_WRITE   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WB_MODE = 2'd0,
        CFG_REPLACE = 2'd1,
        CFG_OFFSET  = 2'd2,
        CFG_SEED    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              mode;
    } t_in_word;

    typedef struct packed {
        logic              hit;
        logic [1:0]        way;
        logic              fill_read;
        logic              mem_write;
        logic              write_back;
        logic [ADDR_W-1:0] victim_tag;
        logic [CNT_W-1:0]  hit_total;
        logic [CNT_W-1:0]  miss_total;
        logic [CNT_W-1:0]  mem_read_total;
        logic [CNT_W-1:0]  mem_write_total;
        logic [CNT_W-1:0]  write_back_total;
    } t_out_word;

    // Saturating counter add of a small increment.
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                                 input logic [1:0] inc);
        logic [CNT_W:0] sum;
        sum = {1'b0, cnt} + {{(CNT_W-1){1'b0}}, inc};
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

    // One step of the Galois LFSR, shifting right.
    function automatic logic [15:0] lfsr_next(input logic [15:0] v);
        return (v >> 1) ^ (v[0] ? LFSR_MASK : 16'd0);
    endfunction

endpackage

// ===== src/sact_tag_ram.sv =====
// Tag memory of the cache controller: one memory per way, indexed by set.
// Read data is registered; a write to the set being read in the same cycle is forwarded.
// Depends on sact_pkg for default sizes.
`timescale 1ns / 1ps

module sact_tag_ram #(
    parameter int SETS  = sact_pkg::SETS_DEF,
    parameter int WAYS  = sact_pkg::WAYS_DEF,
    parameter int SET_W = 1,
    parameter int WAY_W = 1,
    parameter int TAG_W = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rd_en,
    input  logic [SET_W-1:0]               i_rd_set,
    input  logic                           i_wr_en,
    input  logic [SET_W-1:0]               i_wr_set,
    input  logic [WAY_W-1:0]               i_wr_way,
    input  logic [TAG_W-1:0]               i_wr_tag,
    output logic [WAYS-1:0][TAG_W-1:0]     o_rd_tag
);

    for (genvar g = 0; g < WAYS; g++) begin : g_way
        logic [TAG_W-1:0] r_mem [SETS];
        logic             s_wr_here;

        assign s_wr_here = i_wr_en && (i_wr_way == WAY_W'(g));

        always_ff @(posedge i_clk) begin
            if (s_wr_here) begin
                r_mem[i_wr_set] <= i_wr_tag;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_rd_en) begin
                if (s_wr_here && (i_wr_set == i_rd_set)) begin
                    o_rd_tag[g] <= i_wr_tag;
                end else begin
                    o_rd_tag[g] <= r_mem[i_rd_set];
                end
            end
        end
    end

endmodule

// ===== src/set_assoc_cache_tag_controller.sv =====
// Accepted words go to the input register, then their results to the result register.
// Throughput: one access per cycle unless the result side stalls; the tag memory read
// is at acceptance; lookup, victim choice and state update run between the two registers.
// Reset clears valid and dirty bits and counters, sets ages to way order, loads the
// configuration defaults and the LFSR seed. No clearing pass; tags are undefined until
// written. SETS and WAYS must be powers of two; the block itself does not enforce this.
`timescale 1ns / 1ps

module set_assoc_cache_tag_controller #(
    parameter int SETS = sact_pkg::SETS_DEF,
    parameter int WAYS = sact_pkg::WAYS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  sact_pkg::t_in_word               i_in_word,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output sact_pkg::t_out_word              o_out_word,
    input  logic                             i_cfg_we,
    input  logic [sact_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sact_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int SET_BITS = $clog2(SETS);
    localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AGE_W    = WAY_W;
    localparam int TAG_W    = sact_pkg::ADDR_W - SET_BITS;
    localparam int CNT_W    = sact_pkg::CNT_W;

    // Configuration registers and LFSR.
    logic        r_wb_mode;
    logic        r_replace_mode;
    logic [3:0]  r_offset_bits;
    logic [15:0] r_lfsr;

    // Line state.
    logic [WAYS-1:0]            r_valid [SETS];
    logic [WAYS-1:0]            r_dirty [SETS];
    logic [WAYS-1:0][AGE_W-1:0] r_age   [SETS];

    // Running counters.
    logic [CNT_W-1:0] r_cnt_hit, r_cnt_miss, r_cnt_rd, r_cnt_wr, r_cnt_wb;
    logic [CNT_W-1:0] n_cnt_hit, n_cnt_miss, n_cnt_rd, n_cnt_wr, n_cnt_wb;

    // Input stage.
    logic             r_in_valid;
    logic [SET_W-1:0] r_in_set;
    logic [TAG_W-1:0] r_in_tag;
    logic             r_in_write;

    // Result stage.
    logic                r_out_valid;
    sact_pkg::t_out_word r_out_word;

    logic                        s_adv, s_acc;
    logic [sact_pkg::ADDR_W-1:0] s_block;
    logic [SET_W-1:0]            s_acc_set;
    logic [WAYS-1:0][TAG_W-1:0]  s_rd_tag;

    logic                        s_hit, s_has_empty, s_lru_found;
    logic [WAY_W-1:0]            s_hit_way, s_empty_way, s_lru_way, s_rand_way, s_way;
    logic                        s_full_miss, s_lfsr_step, s_wb, s_wt_write;
    logic [15:0]                 s_lfsr_next;
    logic [1:0]                  s_mw_cnt;
    logic [AGE_W-1:0]            s_age_ref;
    logic [WAYS-1:0][AGE_W-1:0]  n_age_row;
    logic                        n_dirty;
    logic [WAYS-1:0]             s_valid_row, s_dirty_row;
    logic [WAYS-1:0][AGE_W-1:0]  s_age_row;

    assign s_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || s_adv;
    assign s_acc      = i_in_valid && o_in_ready;

    // Block number and set index of the arriving word.
    assign s_block   = i_in_word.address >> r_offset_bits;
    assign s_acc_set = (SET_BITS > 0) ? s_block[SET_W-1:0] : '0;

    sact_tag_ram #(
        .SETS  (SETS),
        .WAYS  (WAYS),
        .SET_W (SET_W),
        .WAY_W (WAY_W),
        .TAG_W (TAG_W)
    ) u_tag_ram (
        .i_clk    (i_clk),
        .i_rd_en  (s_acc),
        .i_rd_set (s_acc_set),
        .i_wr_en  (s_adv && !s_hit),
        .i_wr_set (r_in_set),
        .i_wr_way (s_way),
        .i_wr_tag (r_in_tag),
        .o_rd_tag (s_rd_tag)
    );

    assign s_valid_row = r_valid[r_in_set];
    assign s_dirty_row = r_dirty[r_in_set];
    assign s_age_row   = r_age[r_in_set];
    assign s_lfsr_next = sact_pkg::lfsr_next(r_lfsr);
    assign s_rand_way  = (WAYS > 1) ? s_lfsr_next[WAY_W-1:0] : '0;

    always_comb begin
        s_hit       = 1'b0;
        s_hit_way   = '0;
        s_has_empty = 1'b0;
        s_empty_way = '0;
        s_lru_found = 1'b0;
        s_lru_way   = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (!s_hit && s_valid_row[i] && (s_rd_tag[i] == r_in_tag)) begin
                s_hit     = 1'b1;
                s_hit_way = WAY_W'(i);
            end
            if (!s_has_empty && !s_valid_row[i]) begin
                s_has_empty = 1'b1;
                s_empty_way = WAY_W'(i);
            end
            // Ages form a permutation, so the oldest way holds the top age.
            if (!s_lru_found && (s_age_row[i] == AGE_W'(WAYS - 1))) begin
                s_lru_found = 1'b1;
                s_lru_way   = WAY_W'(i);
            end
        end

        s_full_miss = !s_hit && !s_has_empty;
        s_lfsr_step = s_full_miss && r_replace_mode;
        if (s_hit) begin
            s_way = s_hit_way;
        end else if (s_has_empty) begin
            s_way = s_empty_way;
        end else if (r_replace_mode) begin
            s_way = s_rand_way;
        end else begin
            s_way = s_lru_way;
        end

        s_wb       = !s_hit && s_valid_row[s_way] && s_dirty_row[s_way];
        s_wt_write = (r_in_write == sact_pkg::MODE_WRITE) && !r_wb_mode;
        s_mw_cnt   = {1'b0, s_wt_write} + {1'b0, s_wb};

        if (s_hit) begin
            n_dirty = (r_in_write && r_wb_mode) ? 1'b1 : s_dirty_row[s_way];
        end else begin
            n_dirty = r_in_write && r_wb_mode;
        end

        s_age_ref = s_age_row[s_way];
        for (int i = 0; i < WAYS; i++) begin
            if (WAY_W'(i) == s_way) begin
                n_age_row[i] = '0;
            end else if (s_age_row[i] < s_age_ref) begin
                n_age_row[i] = s_age_row[i] + AGE_W'(1);
            end else begin
                n_age_row[i] = s_age_row[i];
            end
        end

        n_cnt_hit  = sact_pkg::sat_add(r_cnt_hit, {1'b0, s_hit});
        n_cnt_miss = sact_pkg::sat_add(r_cnt_miss, {1'b0, !s_hit});
        n_cnt_rd   = sact_pkg::sat_add(r_cnt_rd, {1'b0, !s_hit});
        n_cnt_wr   = sact_pkg::sat_add(r_cnt_wr, s_mw_cnt);
        n_cnt_wb   = sact_pkg::sat_add(r_cnt_wb, {1'b0, s_wb});
    end

    // Configuration and LFSR.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_mode      <= 1'b1;
            r_replace_mode <= 1'b0;
            r_offset_bits  <= sact_pkg::OFFSET_RESET;
            r_lfsr         <= sact_pkg::SEED_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sact_pkg::CFG_WB_MODE: r_wb_mode      <= i_cfg_data[0];
                    sact_pkg::CFG_REPLACE: r_replace_mode <= i_cfg_data[0];
                    sact_pkg::CFG_OFFSET:  r_offset_bits  <= i_cfg_data[3:0];
                    // A zero seed would lock the LFSR, so it loads as one.
                    sact_pkg::CFG_SEED: begin
                        r_lfsr <= (i_cfg_data == '0) ? 16'd1 : i_cfg_data;
                    end
                    default: ;
                endcase
            end
            if (s_adv && s_lfsr_step) begin
                r_lfsr <= s_lfsr_next;
            end
        end
    end

    // Input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_acc) begin
            r_in_valid <= 1'b1;
        end else if (s_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_in_set   <= s_acc_set;
            r_in_tag   <= TAG_W'(s_block >> SET_BITS);
            r_in_write <= i_in_word.mode;
        end
    end

    // Line state and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SETS; s++) begin
                r_valid[s] <= '0;
                r_dirty[s] <= '0;
                for (int w = 0; w < WAYS; w++) begin
                    r_age[s][w] <= AGE_W'(w);
                end
            end
            r_cnt_hit  <= '0;
            r_cnt_miss <= '0;
            r_cnt_rd   <= '0;
            r_cnt_wr   <= '0;
            r_cnt_wb   <= '0;
        end else if (s_adv) begin
            r_valid[r_in_set][s_way] <= 1'b1;
            r_dirty[r_in_set][s_way] <= n_dirty;
            r_age[r_in_set]          <= n_age_row;
            r_cnt_hit  <= n_cnt_hit;
            r_cnt_miss <= n_cnt_miss;
            r_cnt_rd   <= n_cnt_rd;
            r_cnt_wr   <= n_cnt_wr;
            r_cnt_wb   <= n_cnt_wb;
        end
    end

    // Result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_out_word.hit              <= s_hit;
            r_out_word.way              <= 2'(s_way);
            r_out_word.fill_read        <= !s_hit;
            r_out_word.mem_write        <= (s_mw_cnt != 2'd0);
            r_out_word.write_back       <= s_wb;
            r_out_word.victim_tag       <= s_wb ? sact_pkg::ADDR_W'(s_rd_tag[s_way]) : '0;
            r_out_word.hit_total        <= n_cnt_hit;
            r_out_word.miss_total       <= n_cnt_miss;
            r_out_word.mem_read_total   <= n_cnt_rd;
            r_out_word.mem_write_total  <= n_cnt_wr;
            r_out_word.write_back_total <= n_cnt_wb;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Every miss reads a block, so the two totals move together.
    a_read_tracks_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.mem_read_total == o_out_word.miss_total))
        else $error("memory read total differs from miss total");

    a_wb_is_miss_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.write_back) |->
            (o_out_word.mem_write && !o_out_word.hit))
        else $error("write-back without a miss and a memory write");

    a_touched_age_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_adv |=> (r_age[$past(r_in_set)][$past(s_way)] == '0))
        else $error("touched way did not become most recent");

    a_touched_line_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_adv |=> r_valid[$past(r_in_set)][$past(s_way)])
        else $error("accessed line is not valid afterwards");

    a_lfsr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != '0)
        else $error("victim LFSR locked at zero");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench for set_assoc_cache_tag_controller: a directed table of accesses and register
// writes, then random phases of accesses under changing policies, scored by a local model.
// Depends on sact_pkg and the controller RTL.

module tb;

    localparam int NSETS        = sact_pkg::SETS_DEF;
    localparam int NWAYS        = sact_pkg::WAYS_DEF;
    localparam int NLINES       = NSETS * NWAYS;
    localparam int RANDOM_ITEMS = 950;
    localparam int ADDR_W       = sact_pkg::ADDR_W;
    localparam int CNT_W        = sact_pkg::CNT_W;
    localparam int CFG_DATA_W   = sact_pkg::CFG_DATA_W;

    typedef struct packed {
        logic       hit;
        logic [1:0] way;
        logic       fill_read;
        logic       mem_write;
        logic       write_back;
    } t_pin;

    typedef struct packed {
        logic                  is_cfg;
        sact_pkg::t_cfg_idx    idx;
        logic [CFG_DATA_W-1:0] data;
        sact_pkg::t_in_word    access;
        logic                  pinned;
        t_pin                  pin;
    } t_row;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    sact_pkg::t_in_word    in_word   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    sact_pkg::t_out_word   out_word;
    logic                  cfg_we    = 1'b0;
    sact_pkg::t_cfg_idx    cfg_index = sact_pkg::CFG_WB_MODE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Typed-in fields that travel with a directed word.
    logic                  pin_on    = 1'b0;
    t_pin                  pin_val   = '0;

    int                    burst_left = 0;
    logic                  gapless    = 1'b0;
    int                    fail_count = 0;
    sact_pkg::t_out_word   pending_lookups [$];

    // Model of the tag store, policies and counters.
    logic [ADDR_W-1:0]     line_tag   [NLINES];
    logic                  line_valid [NLINES];
    logic                  line_dirty [NLINES];
    logic [1:0]            line_age   [NLINES];
    logic [15:0]           rand_state;
    logic                  cur_wb;
    logic                  cur_repl;
    logic [3:0]            cur_offs;
    logic [CNT_W-1:0]      n_hit, n_miss, n_fill, n_memw, n_wback;

    set_assoc_cache_tag_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_600_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] c, input int n);
        logic [CNT_W:0] s;
        s = {1'b0, c} + (CNT_W + 1)'(n);
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    function automatic sact_pkg::t_out_word predict_lookup(input sact_pkg::t_in_word acc);
        logic [ADDR_W-1:0]   blk;
        logic [ADDR_W-1:0]   tag;
        int                  base;
        int                  way;
        int                  empty;
        int                  nwr;
        logic                found;
        logic                wr;
        logic [1:0]          oldest;
        logic [1:0]          touched_age;
        sact_pkg::t_out_word r;
        blk   = acc.address >> cur_offs;
        base  = int'(blk % ADDR_W'(NSETS)) * NWAYS;
        tag   = blk / ADDR_W'(NSETS);
        wr    = (acc.mode == sact_pkg::MODE_WRITE);
        r     = '0;
        found = 1'b0;
        way   = 0;
        empty = -1;
        nwr   = 0;
        for (int w = 0; w < NWAYS; w++) begin
            if (!found) begin
                if (line_valid[base + w] && line_tag[base + w] == tag) begin
                    found = 1'b1;
                    way   = w;
                end else if (!line_valid[base + w] && empty < 0) begin
                    empty = w;
                end
            end
        end
        if (found) begin
            if (wr) begin
                if (cur_wb) begin
                    line_dirty[base + way] = 1'b1;
                end else begin
                    nwr++;
                end
            end
            n_hit = sat_bump(n_hit, 1);
        end else begin
            if (empty >= 0) begin
                way = empty;
            end else if (cur_repl) begin
                rand_state = {1'b0, rand_state[15:1]}
                           ^ (rand_state[0] ? sact_pkg::LFSR_MASK : 16'h0000);
                way = int'(rand_state % 16'(NWAYS));
            end else begin
                // Oldest way wins; the strict compare keeps the lowest way on a tie.
                oldest = '0;
                for (int w = 0; w < NWAYS; w++) begin
                    if (line_age[base + w] > oldest) begin
                        oldest = line_age[base + w];
                        way    = w;
                    end
                end
            end
            if (line_valid[base + way] && line_dirty[base + way]) begin
                r.write_back = 1'b1;
                r.victim_tag = line_tag[base + way];
                nwr++;
                n_wback = sat_bump(n_wback, 1);
            end
            line_tag[base + way]   = tag;
            line_valid[base + way] = 1'b1;
            if (wr && !cur_wb) begin
                nwr++;
            end
            line_dirty[base + way] = wr && cur_wb;
            n_miss = sat_bump(n_miss, 1);
            n_fill = sat_bump(n_fill, 1);
        end
        touched_age = line_age[base + way];
        for (int w = 0; w < NWAYS; w++) begin
            if (line_age[base + w] < touched_age) begin
                line_age[base + w]++;
            end
        end
        line_age[base + way] = '0;
        if (nwr > 0) begin
            n_memw = sat_bump(n_memw, nwr);
        end
        r.hit              = found;
        r.way              = 2'(way);
        r.fill_read        = !found;
        r.mem_write        = (nwr > 0);
        r.hit_total        = n_hit;
        r.miss_total       = n_miss;
        r.mem_read_total   = n_fill;
        r.mem_write_total  = n_memw;
        r.write_back_total = n_wback;
        return r;
    endfunction

    function automatic string word_text(input sact_pkg::t_out_word w);
        return $sformatf({"hit=%0d way=%0d fill=%0d memw=%0d wb=%0d vtag=%h ",
                          "cnt=%0d/%0d/%0d/%0d/%0d"},
                         w.hit, w.way, w.fill_read, w.mem_write, w.write_back, w.victim_tag,
                         w.hit_total, w.miss_total, w.mem_read_total, w.mem_write_total,
                         w.write_back_total);
    endfunction

    task automatic flag_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // Scoreboard: retire results, then log newly accepted words and register writes.
    always @(posedge i_clk) begin
        sact_pkg::t_out_word want;
        if (!i_rst_n) begin
            for (int l = 0; l < NLINES; l++) begin
                line_tag[l]   = '0;
                line_valid[l] = 1'b0;
                line_dirty[l] = 1'b0;
                line_age[l]   = 2'(l % NWAYS);
            end
            rand_state = sact_pkg::SEED_RESET;
            cur_wb     = 1'b1;
            cur_repl   = 1'b0;
            cur_offs   = sact_pkg::OFFSET_RESET;
            n_hit      = '0;
            n_miss     = '0;
            n_fill     = '0;
            n_memw     = '0;
            n_wback    = '0;
        end else begin
            if (out_valid && out_ready) begin
                if (pending_lookups.size() == 0) begin
                    flag_failure({"result with nothing pending: ", word_text(out_word)});
                end else begin
                    want = pending_lookups.pop_front();
                    if (out_word.hit !== want.hit || out_word.way !== want.way
                            || out_word.fill_read !== want.fill_read
                            || out_word.mem_write !== want.mem_write
                            || out_word.write_back !== want.write_back
                            || out_word.victim_tag !== want.victim_tag
                            || out_word.hit_total !== want.hit_total
                            || out_word.miss_total !== want.miss_total
                            || out_word.mem_read_total !== want.mem_read_total
                            || out_word.mem_write_total !== want.mem_write_total
                            || out_word.write_back_total !== want.write_back_total) begin
                        flag_failure({"mismatch\n  expected ", word_text(want),
                                      "\n  actual   ", word_text(out_word)});
                    end
                end
            end
            if (in_valid && in_ready) begin
                want = predict_lookup(in_word);
                if (pin_on) begin
                    want.hit        = pin_val.hit;
                    want.way        = pin_val.way;
                    want.fill_read  = pin_val.fill_read;
                    want.mem_write  = pin_val.mem_write;
                    want.write_back = pin_val.write_back;
                end
                pending_lookups.push_back(want);
            end
            if (cfg_we) begin
                case (cfg_index)
                    sact_pkg::CFG_WB_MODE: cur_wb   = cfg_data[0];
                    sact_pkg::CFG_REPLACE: cur_repl = cfg_data[0];
                    sact_pkg::CFG_OFFSET:  cur_offs = cfg_data[3:0];
                    sact_pkg::CFG_SEED: begin
                        // A zero seed would lock the LFSR, so it loads as one.
                        rand_state = (cfg_data == 16'h0000) ? 16'h0001 : cfg_data;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Result side backpressure, switching among four patterns at random.
    int stall_style = 0;
    int stall_tick  = 0;
    always @(posedge i_clk) begin
        stall_tick++;
        if (stall_tick % 97 == 0) begin
            stall_style = $urandom_range(0, 3);
        end
        case (stall_style)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= (stall_tick % 9) >= 4;
            default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic send_word(input sact_pkg::t_in_word w, input logic pinned, input t_pin pv);
        int gap;
        in_valid <= 1'b1;
        in_word  <= w;
        pin_on   <= pinned;
        pin_val  <= pv;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = gapless ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_reg(input sact_pkg::t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly a few tags per set so that sets fill, hit and evict; some fully random addresses.
    function automatic logic [ADDR_W-1:0] pick_address();
        int                roll;
        logic [ADDR_W-1:0] blk;
        logic [ADDR_W-1:0] low_mask;
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            return $urandom();
        end
        blk = ADDR_W'($urandom_range(0, roll < 85 ? 5 : 60)) * ADDR_W'(NSETS)
            + ADDR_W'($urandom_range(0, NSETS - 1));
        low_mask = (ADDR_W'(1) << cur_offs) - ADDR_W'(1);
        return (blk << cur_offs) | ($urandom() & low_mask);
    endfunction

    function automatic t_row row_acc(input logic [ADDR_W-1:0] addr, input logic mode);
        t_row row;
        row                = '0;
        row.idx            = sact_pkg::CFG_WB_MODE;
        row.access.address = addr;
        row.access.mode    = mode;
        return row;
    endfunction

    function automatic t_row row_pin(input logic [ADDR_W-1:0] addr, input logic mode,
                                     input logic h, input logic [1:0] w, input logic f,
                                     input logic m, input logic b);
        t_row row;
        row        = row_acc(addr, mode);
        row.pinned = 1'b1;
        row.pin    = {h, w, f, m, b};
        return row;
    endfunction

    function automatic t_row row_cfg(input sact_pkg::t_cfg_idx idx,
                                     input logic [CFG_DATA_W-1:0] value);
        t_row row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = value;
        return row;
    endfunction

    initial begin
        t_row               plan [$];
        sact_pkg::t_in_word acc;
        int                 sent;
        int                 phase;
        int                 phase_len;
        logic [3:0]         offs_val;
        logic [15:0]        seed_val;

        plan.push_back(row_pin(32'h0000_0000, 1'b0, 1'b0, 2'd0, 1'b1, 1'b0, 1'b0));
        plan.push_back(row_pin(32'h0000_0000, 1'b1, 1'b1, 2'd0, 1'b0, 1'b0, 1'b0));
        plan.push_back(row_pin(32'hFFFF_FFFF, 1'b0, 1'b0, 2'd0, 1'b1, 1'b0, 1'b0));
        plan.push_back(row_pin(32'hFFFF_FFFF, 1'b1, 1'b1, 2'd0, 1'b0, 1'b0, 1'b0));
        plan.push_back(row_pin(32'h0000_0080, 1'b0, 1'b0, 2'd1, 1'b1, 1'b0, 1'b0));
        plan.push_back(row_pin(32'h0000_0100, 1'b0, 1'b0, 2'd2, 1'b1, 1'b0, 1'b0));
        plan.push_back(row_pin(32'h0000_0180, 1'b0, 1'b0, 2'd3, 1'b1, 1'b0, 1'b0));
        // Set 0 is full now and its oldest line is the one dirtied by the first write.
        plan.push_back(row_pin(32'h0000_0200, 1'b0, 1'b0, 2'd0, 1'b1, 1'b1, 1'b1));
        plan.push_back(row_cfg(sact_pkg::CFG_WB_MODE, 16'h0000));
        plan.push_back(row_pin(32'h0000_0080, 1'b1, 1'b1, 2'd1, 1'b0, 1'b1, 1'b0));
        plan.push_back(row_pin(32'h0000_0280, 1'b1, 1'b0, 2'd2, 1'b1, 1'b1, 1'b0));
        // Write-through misses fill set 7, then evict the line dirtied under write-back.
        plan.push_back(row_acc(32'h0000_0070, 1'b1));
        plan.push_back(row_acc(32'h0000_00F0, 1'b1));
        plan.push_back(row_acc(32'h0000_0170, 1'b1));
        plan.push_back(row_pin(32'h0000_01F0, 1'b1, 1'b0, 2'd0, 1'b1, 1'b1, 1'b1));
        plan.push_back(row_cfg(sact_pkg::CFG_REPLACE, 16'h0001));
        plan.push_back(row_cfg(sact_pkg::CFG_SEED, 16'h0000));
        plan.push_back(row_acc(32'h0000_0300, 1'b0));
        plan.push_back(row_acc(32'h0000_0380, 1'b1));
        plan.push_back(row_acc(32'h0000_0400, 1'b0));
        plan.push_back(row_cfg(sact_pkg::CFG_OFFSET, 16'h000F));
        plan.push_back(row_acc(32'hFFFF_FFFF, 1'b0));
        plan.push_back(row_acc(32'h8000_0000, 1'b1));
        plan.push_back(row_cfg(sact_pkg::CFG_OFFSET, 16'h0000));
        plan.push_back(row_acc(32'h0000_0007, 1'b0));
        plan.push_back(row_acc(32'h0000_000F, 1'b1));
        plan.push_back(row_cfg(sact_pkg::CFG_OFFSET, 16'h000C));
        plan.push_back(row_acc(32'hABCD_E123, 1'b1));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].is_cfg) begin
                drain();
                set_reg(plan[r].idx, plan[r].data);
            end else begin
                send_word(plan[r].access, plan[r].pinned, plan[r].pin);
            end
        end

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            drain();
            gapless = ($urandom_range(0, 3) == 0);
            if (phase < 2 || $urandom_range(0, 1) == 1) begin
                set_reg(sact_pkg::CFG_WB_MODE, 16'($urandom()));
            end
            if (phase < 2 || $urandom_range(0, 1) == 1) begin
                set_reg(sact_pkg::CFG_REPLACE, 16'($urandom()));
            end
            case (phase)
                0:       offs_val = 4'd0;
                1:       offs_val = 4'd15;
                2:       offs_val = 4'd12;
                default: offs_val = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(13, 15))
                                                                : 4'($urandom_range(0, 12));
            endcase
            if (phase < 3 || $urandom_range(0, 1) == 1) begin
                set_reg(sact_pkg::CFG_OFFSET, {12'($urandom()), offs_val});
            end
            case (phase)
                0:       seed_val = 16'hFFFF;
                1:       seed_val = 16'h0001;
                2:       seed_val = 16'h0000;
                default: seed_val = 16'($urandom());
            endcase
            if (phase < 3 || $urandom_range(0, 1) == 1) begin
                set_reg(sact_pkg::CFG_SEED, seed_val);
            end
            phase_len = $urandom_range(60, 140);
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                acc.address = pick_address();
                acc.mode    = 1'($urandom_range(0, 1));
                send_word(acc, 1'b0, '0);
                sent++;
            end
            phase++;
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending_lookups.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/sact_pkg.sv
src/sact_tag_ram.sv
src/set_assoc_cache_tag_controller.sv
verif/tb.sv
